// ----- design/awvn_pkg.sv -----
// Package with shared types and constants of the vertex normal block.
package awvn_pkg;

	localparam int ACC_BITS = 44;
	localparam int IDX_BITS = 10;
	localparam int OUT_BITS = 16;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FACE  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef logic signed [ACC_BITS-1:0] acc_t;

endpackage

// ----- design/awvn_if.sv -----
// Valid/ready channel interfaces for command words and result words.
interface awvn_in_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [9:0]                   vertex_index;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;
	logic [9:0]                   corner_a;
	logic [9:0]                   corner_b;
	logic [9:0]                   corner_c;
	modport source (output valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface awvn_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic               degenerate;
	logic [9:0]         queried_index;
	modport source (output valid, normal_x, normal_y, normal_z, degenerate,
		queried_index, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
		queried_index, output ready);
endinterface

// ----- design/awvn_norm.sv -----
// Iterative normalizer: scales an accumulated vector to unit length in Q1.14.
module awvn_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  awvn_pkg::acc_t        acc_x,
	input  awvn_pkg::acc_t        acc_y,
	input  awvn_pkg::acc_t        acc_z,
	output logic                  done,
	output logic signed [15:0]    nx,
	output logic signed [15:0]    ny,
	output logic signed [15:0]    nz,
	output logic                  degen
);
	import awvn_pkg::*;

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIV, N_DONE
	} nstate_t;

	nstate_t     state_q;
	logic [43:0] m_q [3];
	logic [2:0]  neg_q;
	logic [63:0] sq_q;
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic [1:0]  k_q;
	logic [1:0]  sqk_q;
	logic [45:0] num_q;
	logic [15:0] quo_q;
	logic [15:0] res_q [3];

	logic [43:0] maxm;
	logic [63:0] trial;
	logic [63:0] rem_sh;
	logic [46:0] num_sh;
	logic [31:0] prod;
	logic [15:0] qv;

	always_comb begin
		maxm = m_q[0];
		if (m_q[1] > maxm) maxm = m_q[1];
		if (m_q[2] > maxm) maxm = m_q[2];
		// Restoring root, two radicand bits per step.
		rem_sh = {rem_q[61:0], sq_q[63:62]};
		trial  = {30'd0, root_q, 2'b01};
		// Restoring divide of the rounded numerator by the root.
		num_sh = {num_q, 1'b0};
		prod   = m_q[sqk_q][31:0];
		qv     = neg_q[k_q] ? 16'(0 - quo_q) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done    <= 1'b0;
			degen   <= 1'b0;
			nx      <= '0;
			ny      <= '0;
			nz      <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						neg_q  <= {acc_z[43], acc_y[43], acc_x[43]};
						m_q[0] <= acc_x[43] ? 44'(-acc_x) : acc_x;
						m_q[1] <= acc_y[43] ? 44'(-acc_y) : acc_y;
						m_q[2] <= acc_z[43] ? 44'(-acc_z) : acc_z;
						state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (maxm == '0) begin
						degen   <= 1'b1;
						nx      <= '0;
						ny      <= '0;
						nz      <= '0;
						done    <= 1'b1;
						state_q <= N_IDLE;
					end else if (maxm >= 44'(64'd1 << 30)) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (maxm < 44'(64'd1 << 29)) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						sq_q    <= '0;
						sqk_q   <= 2'd0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					sq_q <= sq_q + 64'(prod * prod);
					if (sqk_q == 2'd2) begin
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= '0;
						state_q <= N_ROOT;
					end
					sqk_q <= sqk_q + 2'd1;
				end
				N_ROOT: begin
					sq_q <= {sq_q[61:0], 2'b00};
					if (cnt_q == 6'd31) begin
						// After the last step the root is the partial root plus one
						// bit, so half the root is the partial root itself.
						root_q  <= {root_q[30:0], (rem_sh >= trial)};
						rem_q   <= '0;
						k_q     <= 2'd0;
						cnt_q   <= '0;
						num_q   <= {m_q[0][31:0], 14'd0} + 46'(root_q);
						quo_q   <= '0;
						state_q <= N_DIV;
					end else begin
						if (rem_sh >= trial) begin
							rem_q  <= rem_sh - trial;
							root_q <= {root_q[30:0], 1'b1};
						end else begin
							rem_q  <= rem_sh;
							root_q <= {root_q[30:0], 1'b0};
						end
						cnt_q <= cnt_q + 6'd1;
					end
				end
				N_DIV: begin
					// Shift-subtract over 46 numerator bits; partial remainder
					// lives in rem_q.
					num_q <= num_sh[45:0];
					if ({rem_q[62:0], num_q[45]} >= 64'(root_q)) begin
						rem_q <= {rem_q[62:0], num_q[45]} - 64'(root_q);
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], num_q[45]};
						quo_q <= {quo_q[14:0], 1'b0};
					end
					if (cnt_q == 6'd45) begin
						state_q <= N_DONE;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				N_DONE: begin
					res_q[k_q] <= qv;
					if (k_q == 2'd2) begin
						nx      <= res_q[0];
						ny      <= res_q[1];
						nz      <= qv;
						degen   <= 1'b0;
						done    <= 1'b1;
						state_q <= N_IDLE;
					end else begin
						k_q     <= k_q + 2'd1;
						cnt_q   <= '0;
						rem_q   <= '0;
						quo_q   <= '0;
						num_q   <= {m_q[k_q + 2'd1][31:0], 14'd0} + 46'(root_q[31:1]);
						state_q <= N_DIV;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end
endmodule

// ----- design/area_weighted_vertex_normals.sv -----
// Top level of the area-weighted vertex normal block.
// Commands arrive as words on the in channel: a load writes a vertex position
// and clears its accumulator, a face adds the cross product of its edges
// to the accumulators of its three corners, and a query returns the unit
// normal of one vertex as a word on the out channel.
// Positions and accumulators live in two single-port synchronous memories.
// A face runs three position reads, edge differences, a multiply step and a
// subtract step, then three read-modify-write passes on the accumulator
// memory. A query reads the accumulator and runs the normalizer: a shift
// search of up to 29 steps, three squaring steps, a 32-step root and three
// 46-step divides; a zero sum is answered as degenerate by the shift search.
// One command is in work at a time; the result sits in an output register,
// so the block holds a finished word while the receiver stalls and takes no
// new command until it is taken. After reset the block clears the accumulator
// memory one entry a cycle (1024 entries by default) with ready low; positions
// are not cleared, and a face must name only loaded vertices.
module area_weighted_vertex_normals #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	awvn_in_if.sink   in_ch,
	awvn_out_if.source out_ch
);
	import awvn_pkg::*;

	localparam int DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
	localparam int MW = $clog2(DEPTH);
	localparam int DW = COORD_BITS + 1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOAD, S_RDA, S_RDB, S_RDC, S_EDGE, S_MUL, S_SUB,
		S_ACC_RD, S_ACC_WR, S_QRD, S_QWAIT, S_NORM, S_OUT
	} state_t;

	state_t state_q;

	logic signed [COORD_BITS-1:0] pos_mem [DEPTH][3];
	acc_t acc_mem [DEPTH][3];

	logic [MW-1:0] pos_addr;
	logic signed [COORD_BITS-1:0] pos_rd_q [3];
	logic [MW-1:0] acc_addr;
	logic acc_we;
	acc_t acc_wd [3];
	acc_t acc_rd_q [3];

	logic [MW-1:0] a_q, b_q, c_q;
	logic [MW-1:0] clr_q;
	logic [9:0] idx_q;
	logic signed [COORD_BITS-1:0] pa_q [3];
	logic signed [COORD_BITS-1:0] pb_q [3];
	logic signed [DW-1:0] u_q [3];
	logic signed [DW-1:0] w_q [3];
	logic signed [2*DW-1:0] p1_q [3];
	logic signed [2*DW-1:0] p2_q [3];
	acc_t cr_q [3];
	logic [1:0] corner_q;
	logic load_we;
	logic clr_we;

	logic norm_start, norm_done, norm_degen;
	logic signed [15:0] nx, ny, nz;

	function automatic logic [MW-1:0] to_addr(input logic [9:0] v);
		return MW'(v);
	endfunction

	function automatic logic in_range(input logic [9:0] v);
		return {22'd0, v} < 32'(MAX_VERTICES);
	endfunction

	assign in_ch.ready = (state_q == S_IDLE) && !out_ch.valid;

	always_comb begin
		pos_addr = a_q;
		case (state_q)
			S_RDB:   pos_addr = b_q;
			S_RDC:   pos_addr = c_q;
			default: pos_addr = a_q;
		endcase
		acc_addr = a_q;
		case (corner_q)
			2'd1:    acc_addr = b_q;
			2'd2:    acc_addr = c_q;
			default: acc_addr = a_q;
		endcase
		if (state_q == S_LOAD || state_q == S_QRD) acc_addr = a_q;
		if (clr_we) acc_addr = clr_q;
		acc_we = (state_q == S_ACC_WR) || load_we || clr_we;
		for (int i = 0; i < 3; i++) begin
			acc_wd[i] = (load_we || clr_we) ? '0 : acc_rd_q[i] + cr_q[i];
		end
	end

	assign load_we = (state_q == S_LOAD);
	assign clr_we  = (state_q == S_CLR);

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			pos_mem[a_q] <= pb_q;
		end
		pos_rd_q <= pos_mem[pos_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_addr] <= acc_wd;
		acc_rd_q <= acc_mem[acc_addr];
	end

	assign norm_start = (state_q == S_NORM) && !out_ch.valid;

	awvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.acc_x  (acc_rd_q[0]),
		.acc_y  (acc_rd_q[1]),
		.acc_z  (acc_rd_q[2]),
		.done   (norm_done),
		.nx     (nx),
		.ny     (ny),
		.nz     (nz),
		.degen  (norm_degen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_CLR;
			out_ch.valid      <= 1'b0;
			corner_q          <= 2'd0;
			clr_q             <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (clr_q == MW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_ch.valid && !out_ch.valid) begin
						a_q   <= to_addr(in_ch.corner_a);
						b_q   <= to_addr(in_ch.corner_b);
						c_q   <= to_addr(in_ch.corner_c);
						idx_q <= in_ch.vertex_index;
						corner_q <= 2'd0;
						case (cmd_t'(in_ch.cmd))
							CMD_LOAD: begin
								a_q   <= to_addr(in_ch.vertex_index);
								pb_q  <= '{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
								if (in_range(in_ch.vertex_index)) state_q <= S_LOAD;
							end
							CMD_FACE: begin
								if (in_range(in_ch.corner_a) && in_range(in_ch.corner_b)
									&& in_range(in_ch.corner_c)) state_q <= S_RDA;
							end
							CMD_QUERY: begin
								a_q <= to_addr(in_ch.vertex_index);
								if (in_range(in_ch.vertex_index)) begin
									state_q <= S_QRD;
								end else begin
									out_ch.normal_x      <= '0;
									out_ch.normal_y      <= '0;
									out_ch.normal_z      <= '0;
									out_ch.degenerate    <= 1'b1;
									out_ch.queried_index <= in_ch.vertex_index;
									out_ch.valid         <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_LOAD: state_q <= S_IDLE;
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					pa_q    <= pos_rd_q;
					state_q <= S_RDC;
				end
				S_RDC: begin
					pb_q    <= pos_rd_q;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					// pos_rd_q now holds corner C.
					for (int i = 0; i < 3; i++) begin
						u_q[i] <= DW'(pos_rd_q[i]) - DW'(pa_q[i]);
						w_q[i] <= DW'(pb_q[i]) - DW'(pa_q[i]);
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					p1_q[0] <= u_q[1] * w_q[2];
					p2_q[0] <= u_q[2] * w_q[1];
					p1_q[1] <= u_q[2] * w_q[0];
					p2_q[1] <= u_q[0] * w_q[2];
					p1_q[2] <= u_q[0] * w_q[1];
					p2_q[2] <= u_q[1] * w_q[0];
					state_q <= S_SUB;
				end
				S_SUB: begin
					for (int i = 0; i < 3; i++) begin
						cr_q[i] <= ACC_BITS'(p1_q[i]) - ACC_BITS'(p2_q[i]);
					end
					corner_q <= 2'd0;
					state_q  <= S_ACC_RD;
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					if (corner_q == 2'd2) begin
						corner_q <= 2'd0;
						state_q  <= S_IDLE;
					end else begin
						corner_q <= corner_q + 2'd1;
						state_q  <= S_ACC_RD;
					end
				end
				S_QRD: state_q <= S_QWAIT;
				S_QWAIT: state_q <= S_NORM;
				S_NORM: if (!out_ch.valid) state_q <= S_OUT;
				S_OUT: begin
					if (norm_done) begin
						out_ch.normal_x      <= nx;
						out_ch.normal_y      <= ny;
						out_ch.normal_z      <= nz;
						out_ch.degenerate    <= norm_degen;
						out_ch.queried_index <= idx_q;
						out_ch.valid         <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- verif/area_weighted_vertex_normals_test.sv -----
// Self-checking testbench for the area-weighted vertex normal block.
module area_weighted_vertex_normals_test;
	timeunit 1ns;
	timeprecision 1ps;
	import awvn_pkg::*;

	localparam int NVERT = 1024;
	localparam int RANDOM_WORDS = 1950;

	typedef struct packed {
		cmd_t               cmd;
		logic [9:0]         vi;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic [9:0]         ca;
		logic [9:0]         cb;
		logic [9:0]         cc;
	} cmd_word_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               degen;
		logic [9:0]         idx;
	} normal_word_t;

	typedef struct packed {
		cmd_word_t    w;
		logic         typed;
		normal_word_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	awvn_in_if #(.COORD_BITS(16)) in_ch();
	awvn_out_if out_ch();

	area_weighted_vertex_normals dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #4 clk = ~clk;

	// Mirror of the block's memories.
	logic signed [15:0] vert_pos [NVERT][3];
	logic [43:0] acc_x [NVERT];
	logic [43:0] acc_y [NVERT];
	logic [43:0] acc_z [NVERT];
	bit          is_loaded [NVERT];
	int          loaded_list [$];

	normal_word_t pending_normals [$];
	stim_row_t    rows [$];

	int errors = 0;
	int n_load = 0, n_face = 0, n_query = 0, n_degen = 0, n_results = 0;
	int tx_idle = 10, rx_idle = 70;

	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic normal_word_t unit_normal(input logic [9:0] idx,
			input logic [43:0] ax, input logic [43:0] ay, input logic [43:0] az);
		normal_word_t res;
		logic [43:0] a [3];
		logic [43:0] t;
		logic [63:0] m [3];
		logic [63:0] maxm, sq, r, q;
		bit neg [3];
		res = '0;
		res.degen = 1'b1;
		res.idx = idx;
		a[0] = ax; a[1] = ay; a[2] = az;
		for (int k = 0; k < 3; k++) begin
			neg[k] = a[k][43];
			t = neg[k] ? -a[k] : a[k];
			m[k] = {20'd0, t};
		end
		maxm = m[0];
		if (m[1] > maxm) maxm = m[1];
		if (m[2] > maxm) maxm = m[2];
		if (maxm == 0) return res;
		while (maxm >= (64'd1 << 30)) begin
			for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
			maxm = maxm >> 1;
		end
		while (maxm < (64'd1 << 29)) begin
			for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
			maxm = maxm << 1;
		end
		sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		r = int_root(sq);
		res.degen = 1'b0;
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * 64'd16384 + (r >> 1)) / r;
			if (neg[k]) q = -q;
			case (k)
				0: res.nx = q[15:0];
				1: res.ny = q[15:0];
				default: res.nz = q[15:0];
			endcase
		end
		return res;
	endfunction

	// Updates the mirrored state for one accepted word; returns 1 when a result follows.
	function automatic bit apply_word(input cmd_word_t w, output normal_word_t res);
		logic signed [63:0] u [3], v [3];
		logic signed [63:0] cx, cy, cz;
		logic [9:0] corner [3];
		res = '0;
		case (w.cmd)
			CMD_LOAD: begin
				vert_pos[w.vi][0] = w.px;
				vert_pos[w.vi][1] = w.py;
				vert_pos[w.vi][2] = w.pz;
				acc_x[w.vi] = '0;
				acc_y[w.vi] = '0;
				acc_z[w.vi] = '0;
				if (!is_loaded[w.vi]) loaded_list.push_back(int'(w.vi));
				is_loaded[w.vi] = 1'b1;
				n_load++;
				return 1'b0;
			end
			CMD_FACE: begin
				for (int k = 0; k < 3; k++) begin
					u[k] = 64'(vert_pos[w.cc][k]) - 64'(vert_pos[w.ca][k]);
					v[k] = 64'(vert_pos[w.cb][k]) - 64'(vert_pos[w.ca][k]);
				end
				cx = u[1] * v[2] - u[2] * v[1];
				cy = u[2] * v[0] - u[0] * v[2];
				cz = u[0] * v[1] - u[1] * v[0];
				corner[0] = w.ca; corner[1] = w.cb; corner[2] = w.cc;
				// Repeated corners get the product once per occurrence.
				for (int k = 0; k < 3; k++) begin
					acc_x[corner[k]] = acc_x[corner[k]] + cx[43:0];
					acc_y[corner[k]] = acc_y[corner[k]] + cy[43:0];
					acc_z[corner[k]] = acc_z[corner[k]] + cz[43:0];
				end
				n_face++;
				return 1'b0;
			end
			CMD_QUERY: begin
				res = unit_normal(w.vi, acc_x[w.vi], acc_y[w.vi], acc_z[w.vi]);
				n_query++;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic send_word(input cmd_word_t w, input bit typed, input normal_word_t want);
		normal_word_t res;
		bit has_res;
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= w.cmd;
		in_ch.vertex_index <= w.vi;
		in_ch.pos_x <= w.px;
		in_ch.pos_y <= w.py;
		in_ch.pos_z <= w.pz;
		in_ch.corner_a <= w.ca;
		in_ch.corner_b <= w.cb;
		in_ch.corner_c <= w.cc;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		has_res = apply_word(w, res);
		if (has_res) pending_normals.push_back(typed ? want : res);
	endtask

	function automatic cmd_word_t ld(input int vi, input int x, input int y, input int z);
		cmd_word_t w;
		w = '0;
		w.cmd = CMD_LOAD; w.vi = 10'(vi); w.px = 16'(x); w.py = 16'(y); w.pz = 16'(z);
		w.ca = 10'($urandom); w.cb = 10'($urandom); w.cc = 10'($urandom);
		return w;
	endfunction

	function automatic cmd_word_t fc(input int a, input int b, input int c);
		cmd_word_t w;
		w = '0;
		w.cmd = CMD_FACE; w.ca = 10'(a); w.cb = 10'(b); w.cc = 10'(c);
		w.vi = 10'($urandom); w.px = 16'($urandom); w.py = 16'($urandom);
		w.pz = 16'($urandom);
		return w;
	endfunction

	function automatic cmd_word_t qr(input int vi);
		cmd_word_t w;
		w = fc($urandom, $urandom, $urandom);
		w.cmd = CMD_QUERY; w.vi = 10'(vi);
		return w;
	endfunction

	function automatic normal_word_t nw(input int x, input int y, input int z,
			input bit d, input int idx);
		normal_word_t r;
		r.nx = 16'(x); r.ny = 16'(y); r.nz = 16'(z); r.degen = d; r.idx = 10'(idx);
		return r;
	endfunction

	function automatic void add_row(input cmd_word_t w, input bit typed = 0,
			input normal_word_t want = '0);
		stim_row_t row;
		row.w = w; row.typed = typed; row.want = want;
		rows.push_back(row);
	endfunction

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(3))
			0: return 16'(int'($urandom_range(1023)) - 512);
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_loaded();
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			n_results++;
			if (pending_normals.size() == 0) begin
				$display("%0t: unexpected result word idx=%0d", $time, out_ch.queried_index);
				errors++;
			end else begin
				normal_word_t e;
				e = pending_normals.pop_front();
				if (out_ch.degenerate) n_degen++;
				if (out_ch.normal_x !== e.nx) begin
					$display("%0t: normal_x expected %0d got %0d", $time, e.nx, out_ch.normal_x);
					errors++;
				end
				if (out_ch.normal_y !== e.ny) begin
					$display("%0t: normal_y expected %0d got %0d", $time, e.ny, out_ch.normal_y);
					errors++;
				end
				if (out_ch.normal_z !== e.nz) begin
					$display("%0t: normal_z expected %0d got %0d", $time, e.nz, out_ch.normal_z);
					errors++;
				end
				if (out_ch.degenerate !== e.degen) begin
					$display("%0t: degenerate expected %0b got %0b", $time, e.degen,
						out_ch.degenerate);
					errors++;
				end
				if (out_ch.queried_index !== e.idx) begin
					$display("%0t: queried_index expected %0d got %0d", $time, e.idx,
						out_ch.queried_index);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= rx_idle);

	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		cmd_word_t w;
		int kind, phase_len, waited;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_NONE;
		in_ch.vertex_index = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.pos_z = '0;
		in_ch.corner_a = '0;
		in_ch.corner_b = '0;
		in_ch.corner_c = '0;
		out_ch.ready = 1'b0;
		for (int i = 0; i < NVERT; i++) begin
			is_loaded[i] = 0;
			acc_x[i] = '0; acc_y[i] = '0; acc_z[i] = '0;
			for (int k = 0; k < 3; k++) vert_pos[i][k] = '0;
		end

		add_row(ld(0, 0, 0, 0));
		add_row(ld(1, 256, 0, 0));
		add_row(ld(2, 0, 256, 0));
		add_row(qr(0), 1, nw(0, 0, 0, 1, 0));
		add_row(fc(0, 1, 2));
		add_row(qr(0), 1, nw(0, 0, -16384, 0, 0));
		add_row(fc(0, 0, 1));
		add_row(qr(1), 1, nw(0, 0, -16384, 0, 1));
		add_row(ld(1023, 32767, 32767, 32767));
		add_row(ld(1022, -32768, -32768, -32768));
		add_row(ld(512, 32767, -32768, 0));
		add_row(fc(1022, 1023, 512));
		add_row(fc(1023, 512, 1022));
		add_row(qr(1022));
		add_row(qr(1023));
		add_row(qr(512));
		w = qr(5);
		w.cmd = CMD_NONE;
		add_row(w);
		add_row(ld(2, 100, -200, 300));
		add_row(qr(2), 1, nw(0, 0, 0, 1, 2));
		add_row(ld(3, 512, 0, 0));
		add_row(fc(0, 1, 3));
		add_row(fc(1, 1, 1));
		add_row(qr(3), 1, nw(0, 0, 0, 1, 3));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);

		phase_len = RANDOM_WORDS / 3;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle = 10; rx_idle = 70; end
				1: begin tx_idle = 70; rx_idle = 10; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			for (int n = 0; n < phase_len; ) begin
				kind = $urandom_range(99);
				if (kind < 25) begin
					// About half the loads land in a small group so faces share corners.
					w = ld($urandom_range(1) ? $urandom_range(31) : $urandom_range(NVERT - 1),
						rand_coord(), rand_coord(), rand_coord());
				end else if (kind < 70) begin
					w = fc(pick_loaded(), pick_loaded(), pick_loaded());
				end else if (kind < 95) begin
					w = qr(pick_loaded());
				end else begin
					w = qr($urandom);
					w.cmd = CMD_NONE;
				end
				send_word(w, 0, '0);
				if (w.cmd != CMD_NONE) n++;
			end
		end
		in_ch.valid <= 1'b0;

		waited = 0;
		while (pending_normals.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);

		if (pending_normals.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, pending_normals.size());
			errors++;
		end
		$display("Sent %0d loads, %0d faces and %0d queries under three idle mixes.",
			n_load, n_face, n_query);
		$display("Checked %0d normal words, %0d of them degenerate; %0d errors.",
			n_results, n_degen, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
